[rtl/bmc_pkg.sv]
// Shared types and constants for the binomial coefficient core.
// No dependencies; compiled first.
package bmc_pkg;

  // Field widths fixed by the item format
  localparam int N_W    = 7;
  localparam int COEF_W = 64;

  // Job queue between the front and back parts
  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = 2;

  // Job kinds decided by the front part
  localparam logic [1:0] KIND_ZERO = 2'd0;  // n below k
  localparam logic [1:0] KIND_ONE  = 2'd1;  // k zero or k equal to n
  localparam logic [1:0] KIND_BIG  = 2'd2;  // n above the built maximum
  localparam logic [1:0] KIND_RUN  = 2'd3;  // needs the multiply/divide loop

  typedef struct packed {
    logic [1:0]     kind;
    logic [N_W-1:0] n;
    logic [N_W-1:0] k;    // already reduced to min(k, n-k) for runs
  } bmc_job_t;

endpackage

[rtl/bmc_in_if.sv]
// Input channel: valid/ready handshake carrying n and k.
// Depends on bmc_pkg.
interface bmc_in_if;
  import bmc_pkg::*;

  logic           valid;
  logic           ready;
  logic [N_W-1:0] n_total;
  logic [N_W-1:0] k_choose;

  modport source (output valid, output n_total, output k_choose, input ready);
  modport sink   (input valid, input n_total, input k_choose, output ready);
endinterface

[rtl/bmc_out_if.sv]
// Output channel: valid/ready handshake carrying the coefficient and error flags.
// Depends on bmc_pkg.
interface bmc_out_if;
  import bmc_pkg::*;

  logic              valid;
  logic              ready;
  logic [COEF_W-1:0] coefficient;
  logic              overflow;
  logic              n_too_large;

  modport source (output valid, output coefficient, output overflow,
                  output n_too_large, input ready);
  modport sink   (input valid, input coefficient, input overflow,
                  input n_too_large, output ready);
endinterface

[rtl/bmc_front.sv]
// Front part: accepts input items, sorts out the trivial cases and reduces k.
// Depends on bmc_pkg and bmc_in_if.
module bmc_front #(
  parameter int MAX_N = 67
) (
  input  logic              clk,
  input  logic              rst,
  bmc_in_if.sink            in_ch,
  output logic              push_valid,
  input  logic              push_ready,
  output bmc_pkg::bmc_job_t push_job
);
  import bmc_pkg::*;

  logic     stg_valid;
  bmc_job_t stg_job;
  bmc_job_t job_next;
  logic     take;

  // Classify the incoming item
  always_comb begin
    job_next.n    = in_ch.n_total;
    job_next.k    = in_ch.k_choose;
    job_next.kind = KIND_RUN;
    if (in_ch.n_total < in_ch.k_choose) begin
      job_next.kind = KIND_ZERO;
    end else if (in_ch.k_choose == '0 || in_ch.k_choose == in_ch.n_total) begin
      job_next.kind = KIND_ONE;
    end else if (in_ch.n_total > N_W'(MAX_N)) begin
      job_next.kind = KIND_BIG;
    end else if ((in_ch.n_total >> 1) < in_ch.k_choose) begin
      job_next.k = in_ch.n_total - in_ch.k_choose;
    end
  end

  assign in_ch.ready = !stg_valid || push_ready;
  assign take        = in_ch.valid && in_ch.ready;
  assign push_valid  = stg_valid;
  assign push_job    = stg_job;

  // Staging register ahead of the queue
  always_ff @(posedge clk) begin
    if (rst) begin
      stg_valid <= 1'b0;
    end else if (take) begin
      stg_valid <= 1'b1;
    end else if (push_ready) begin
      stg_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      stg_job <= job_next;
    end
  end

  // A run job always has 1 <= k <= n/2
  a_run_k_reduced: assert property (@(posedge clk) disable iff (rst)
    stg_valid && stg_job.kind == KIND_RUN |->
      stg_job.k != '0 && stg_job.k <= (stg_job.n >> 1))
    else $error("run job with unreduced k");

  // Jobs flagged too large really exceed the maximum
  a_big_n: assert property (@(posedge clk) disable iff (rst)
    stg_valid && stg_job.kind == KIND_BIG |-> stg_job.n > N_W'(MAX_N))
    else $error("job flagged too large below maximum");

  // A staged job holds until the queue takes it
  a_stage_hold: assert property (@(posedge clk) disable iff (rst)
    stg_valid && !push_ready |=> stg_valid && $stable(stg_job))
    else $error("staged job lost while queue full");

endmodule

[rtl/bmc_queue.sv]
// Short job queue that decouples the front and back parts.
// Depends on bmc_pkg.
module bmc_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push_valid,
  output logic              push_ready,
  input  bmc_pkg::bmc_job_t push_job,
  output logic              pop_valid,
  input  logic              pop_ready,
  output bmc_pkg::bmc_job_t pop_job
);
  import bmc_pkg::*;

  bmc_job_t        slots [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr;
  logic [Q_AW-1:0] rd_ptr;
  logic [Q_AW:0]   count;
  logic            do_push;
  logic            do_pop;

  assign push_ready = count != (Q_AW+1)'(Q_DEPTH);
  assign pop_valid  = count != '0;
  assign pop_job    = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= (Q_AW+1)'(Q_DEPTH))
    else $error("queue count beyond depth");

  a_ptr_gap: assert property (@(posedge clk) disable iff (rst)
    count != (Q_AW+1)'(Q_DEPTH) |-> (wr_ptr - rd_ptr) == count[Q_AW-1:0])
    else $error("queue pointers disagree with count");

  a_full_ptrs: assert property (@(posedge clk) disable iff (rst)
    count == (Q_AW+1)'(Q_DEPTH) |-> wr_ptr == rd_ptr)
    else $error("full queue with pointer gap");

endmodule

[rtl/bmc_back.sv]
// Back part: multiply-then-exact-divide loop with a 2-bit-per-cycle divider,
// plus the result register. Depends on bmc_pkg and bmc_out_if.
module bmc_back #(
  parameter int VALUE_WIDTH = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              pop_valid,
  output logic              pop_ready,
  input  bmc_pkg::bmc_job_t pop_job,
  bmc_out_if.source         out_ch
);
  import bmc_pkg::*;

  localparam int PROD_W  = VALUE_WIDTH + N_W;
  localparam int DIV_W   = VALUE_WIDTH + (VALUE_WIDTH % 2);
  localparam int DIV_CYC = DIV_W / 2;
  localparam int CNT_W   = $clog2(DIV_CYC);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MUL  = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;

  logic [1:0]             state;
  logic [VALUE_WIDTH-1:0] acc;
  logic [DIV_W-1:0]       quo;
  logic [N_W-1:0]         rem;
  logic [N_W-1:0]         i_cnt;
  logic [N_W-1:0]         k_lim;
  logic [N_W-1:0]         nk;
  logic [CNT_W-1:0]       cnt;

  logic                   res_valid;
  logic [COEF_W-1:0]      res_coef;
  logic                   res_ovf;
  logic                   res_big;

  logic                   start;
  logic [N_W-1:0]         mult;
  logic [PROD_W-1:0]      prod;
  logic                   prod_ovf;
  logic [N_W:0]           t1;
  logic [N_W:0]           t2;
  logic                   ge1;
  logic                   ge2;
  logic [N_W-1:0]         r1;
  logic [N_W-1:0]         r2;
  logic [DIV_W-1:0]       quo_next;
  logic [VALUE_WIDTH-1:0] quot;
  logic [N_W-1:0]         nk_new;

  assign pop_ready = state == S_IDLE && !res_valid;
  assign start     = pop_valid && pop_ready;
  assign nk_new    = pop_job.n - pop_job.k;

  // One multiply by n-k+i, overflow when the product leaves VALUE_WIDTH bits
  assign mult     = nk + i_cnt;
  assign prod     = PROD_W'(acc) * PROD_W'(mult);
  assign prod_ovf = prod[PROD_W-1:VALUE_WIDTH] != '0;

  // Two restoring divide steps per cycle, divisor i
  always_comb begin
    t1  = {rem, quo[DIV_W-1]};
    ge1 = t1 >= {1'b0, i_cnt};
    r1  = ge1 ? N_W'(t1 - {1'b0, i_cnt}) : t1[N_W-1:0];
    t2  = {r1, quo[DIV_W-2]};
    ge2 = t2 >= {1'b0, i_cnt};
    r2  = ge2 ? N_W'(t2 - {1'b0, i_cnt}) : t2[N_W-1:0];
  end

  // Quotient after this cycle's two steps; complete on the last divide cycle
  assign quo_next = {quo[DIV_W-3:0], ge1, ge2};
  assign quot     = quo_next[VALUE_WIDTH-1:0];

  // Sequencer and result handshake
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      res_valid <= 1'b0;
    end else begin
      if (res_valid && out_ch.ready) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (start) begin
            if (pop_job.kind == KIND_RUN && pop_job.k > N_W'(1)) begin
              state <= S_MUL;
            end else begin
              res_valid <= 1'b1;
            end
          end
        end
        S_MUL: begin
          if (prod_ovf) begin
            state     <= S_IDLE;
            res_valid <= 1'b1;
          end else begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (cnt == '0 && i_cnt == k_lim) begin
            state     <= S_IDLE;
            res_valid <= 1'b1;
          end else if (cnt == '0) begin
            state <= S_MUL;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Datapath and result payload
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (start) begin
          nk    <= nk_new;
          k_lim <= pop_job.k;
          i_cnt <= N_W'(2);
          acc   <= VALUE_WIDTH'(nk_new) + 1'b1;
          res_ovf <= 1'b0;
          res_big <= pop_job.kind == KIND_BIG;
          case (pop_job.kind)
            KIND_ONE: res_coef <= COEF_W'(1);
            KIND_RUN: res_coef <= COEF_W'(nk_new) + 1'b1;
            default:  res_coef <= '0;
          endcase
        end
      end
      S_MUL: begin
        quo <= DIV_W'(prod[VALUE_WIDTH-1:0]);
        rem <= '0;
        cnt <= CNT_W'(DIV_CYC - 1);
        if (prod_ovf) begin
          res_coef <= '0;
          res_ovf  <= 1'b1;
        end
      end
      S_DIV: begin
        quo <= quo_next;
        rem <= r2;
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          acc      <= quot;
          i_cnt    <= i_cnt + 1'b1;
          res_coef <= COEF_W'(quot);
        end
      end
      default: begin
      end
    endcase
  end

  assign out_ch.valid       = res_valid;
  assign out_ch.coefficient = res_coef;
  assign out_ch.overflow    = res_ovf;
  assign out_ch.n_too_large = res_big;

  // Division remainder always stays below the divisor
  a_rem_below: assert property (@(posedge clk) disable iff (rst)
    state == S_DIV |-> rem < i_cnt)
    else $error("divider remainder not below divisor");

  // Errors report a zero value and never both flags
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && (res_ovf || res_big) |-> res_coef == '0 && !(res_ovf && res_big))
    else $error("error result with nonzero value or both flags");

  // The loop never runs past k
  a_step_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_MUL |-> i_cnt >= N_W'(2) && i_cnt <= k_lim)
    else $error("step index outside 2..k");

endmodule

[rtl/binomial_multiplicative_core.sv]
// Binomial coefficient C(n,k), multiplicative method, one result per item.
// Trivial cases (n<k, k=0, k=n, n too large) go straight to the result register; otherwise
// the loop runs k'-1 multiply/divide steps, k' = min(k, n-k).
// Throughput: one item at a time in the back part, set by its shared 2-bit-per-cycle divider;
// up to four jobs wait in the queue while the front keeps accepting.
// Reset: synchronous, active high; empties the queue and clears all valid flags.
module binomial_multiplicative_core #(
  parameter int MAX_N       = 67,
  parameter int VALUE_WIDTH = 64
) (
  input  logic      clk,
  input  logic      rst,
  bmc_in_if.sink    in_ch,
  bmc_out_if.source out_ch
);
  import bmc_pkg::*;

  logic     push_valid;
  logic     push_ready;
  bmc_job_t push_job;
  logic     pop_valid;
  logic     pop_ready;
  bmc_job_t pop_job;

  bmc_front #(.MAX_N(MAX_N)) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_ch      (in_ch),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_job   (push_job)
  );

  bmc_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_job   (push_job),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_job    (pop_job)
  );

  bmc_back #(.VALUE_WIDTH(VALUE_WIDTH)) u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_job   (pop_job),
    .out_ch    (out_ch)
  );

endmodule

[tb/binomial_multiplicative_core_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for binomial_multiplicative_core: directed and random n/k items
// checked field by field against a local C(n,k) predictor. Needs bmc_pkg, bmc_in_if, bmc_out_if.
module binomial_multiplicative_core_tb;
  import bmc_pkg::*;

  localparam int MAX_N        = 67;
  localparam int VALUE_WIDTH  = 64;
  localparam int CYCLE_LIMIT  = 3_000_000;
  localparam int DRAIN_CYCLES = 1200;
  localparam int SHOWN_ERRORS = 10;

  typedef struct packed {
    logic [COEF_W-1:0] coefficient;
    logic              overflow;
    logic              n_too_large;
  } coef_result_t;

  typedef struct packed {
    logic [N_W-1:0] n;
    logic [N_W-1:0] k;
    coef_result_t   res;
  } binom_entry_t;

  logic clk;
  logic rst;
  bit   gap_enable;
  bit   stall_enable;
  int   mismatch_count;

  binom_entry_t pending_coefs[$];

  bmc_in_if  in_ch();
  bmc_out_if out_ch();

  binomial_multiplicative_core #(
    .MAX_N      (MAX_N),
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_top (
    .clk   (clk),
    .rst   (rst),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  // 4 ns clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Hard stop if the run hangs
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("binomial_multiplicative_core: mismatch");
    $finish;
  end

  // Exact C(n,k) by the multiplicative method, with the block's error flags
  function automatic coef_result_t binomial_expected(input logic [N_W-1:0] n_in,
                                                     input logic [N_W-1:0] k_in);
    coef_result_t r;
    logic [63:0]  n;
    logic [63:0]  k;
    logic [63:0]  acc;
    logic [63:0]  m;
    logic [63:0]  i;
    logic [63:0]  maxv;
    r    = '0;
    n    = 64'(n_in);
    k    = 64'(k_in);
    maxv = {64{1'b1}} >> (64 - VALUE_WIDTH);
    if (n < k) return r;
    if (k == 0 || k == n) begin
      r.coefficient = 64'd1;
      return r;
    end
    if (n > MAX_N) begin
      r.n_too_large = 1'b1;
      return r;
    end
    if ((n >> 1) < k) k = n - k;
    acc = n - k + 1;
    for (i = 2; i <= k; i++) begin
      m = n - k + i;
      // product would not fit: stop with the overflow flag
      if (acc > maxv / m) begin
        r.overflow = 1'b1;
        return r;
      end
      acc = (acc * m) / i;
    end
    r.coefficient = acc & maxv;
    return r;
  endfunction

  task automatic note_mismatch(input string what, input logic [N_W-1:0] n,
                               input logic [N_W-1:0] k, input logic [63:0] exp_v,
                               input logic [63:0] act_v);
    mismatch_count++;
    if (mismatch_count <= SHOWN_ERRORS)
      $display("ERROR %s: n=%0d k=%0d expected %0d got %0d", what, n, k, exp_v, act_v);
  endtask

  // Result checker: compare each accepted item with the oldest prediction
  always @(posedge clk) begin
    binom_entry_t e;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (pending_coefs.size() == 0) begin
        note_mismatch("result with none pending", '0, '0, '0, out_ch.coefficient);
      end else begin
        e = pending_coefs.pop_front();
        if (out_ch.coefficient !== e.res.coefficient)
          note_mismatch("coefficient", e.n, e.k, e.res.coefficient, out_ch.coefficient);
        if (out_ch.overflow !== e.res.overflow)
          note_mismatch("overflow", e.n, e.k, 64'(e.res.overflow), 64'(out_ch.overflow));
        if (out_ch.n_too_large !== e.res.n_too_large)
          note_mismatch("n_too_large", e.n, e.k, 64'(e.res.n_too_large),
                        64'(out_ch.n_too_large));
      end
    end
  end

  // Result-side back-pressure in random bursts
  initial begin
    int hold;
    hold         = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst) begin
        out_ch.ready <= 1'b0;
      end else if (hold > 0) begin
        out_ch.ready <= 1'b0;
        hold--;
      end else if (stall_enable && $urandom_range(0, 3) == 0) begin
        out_ch.ready <= 1'b0;
        hold = $urandom_range(0, 4);
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Send one item; valid stays high unless a gap is inserted before the next one
  task automatic send_item(input int n, input int k);
    binom_entry_t e;
    if (gap_enable && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.n_total  <= N_W'(n);
    in_ch.k_choose <= N_W'(k);
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    e.n   = N_W'(n);
    e.k   = N_W'(k);
    e.res = binomial_expected(N_W'(n), N_W'(k));
    pending_coefs.push_back(e);
  endtask

  // Drop valid and wait until every pending result has come back
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_coefs.size() != 0) @(posedge clk);
  endtask

  // n below k, k zero, k equal to n, including the field extremes
  task automatic test_trivial_cases();
    send_item(0, 0);
    send_item(127, 127);
    send_item(127, 0);
    send_item(0, 127);
    send_item(5, 6);
    send_item(1, 0);
    send_item(1, 1);
  endtask

  // n above the built maximum once the trivial cases are ruled out
  task automatic test_oversize_n();
    send_item(MAX_N + 1, 2);
    send_item(127, 1);
    send_item(100, 50);
    send_item(127, 126);
  endtask

  // Largest reduced k, where intermediate products can exceed 64 bits
  task automatic test_overflow_edge();
    send_item(67, 33);
    send_item(67, 34);
    send_item(66, 33);
    send_item(62, 31);
    send_item(60, 30);
  endtask

  // Small nontrivial runs, both sides of the k reduction
  task automatic test_small_values();
    send_item(2, 1);
    send_item(10, 3);
    send_item(10, 7);
    send_item(67, 1);
    send_item(67, 66);
  endtask

  // Pick a random n/k pair, weighted toward cheap runs
  task automatic send_random_item();
    int sel;
    int n;
    int kr;
    sel = $urandom_range(0, 99);
    if (sel < 20) begin
      // whole field range: mostly trivial or oversize
      send_item($urandom_range(0, 127), $urandom_range(0, 127));
    end else if (sel < 70) begin
      // short loops, either k or n-k small
      n  = $urandom_range(2, MAX_N);
      kr = $urandom_range(1, (n - 1 < 6) ? n - 1 : 6);
      send_item(n, $urandom_range(0, 1) ? kr : n - kr);
    end else if (sel < 85) begin
      n = $urandom_range(2, MAX_N);
      send_item(n, $urandom_range(0, n));
    end else begin
      // near the middle of large n: overflow territory
      n = $urandom_range(50, MAX_N);
      send_item(n, n / 2 + $urandom_range(0, 8) - 4);
    end
  endtask

  // Random items with idling switched on and off in stretches
  task automatic test_random(input int count);
    for (int i = 0; i < count; i++) begin
      if (i % 50 == 0) begin
        gap_enable   = ($urandom_range(0, 3) != 0);
        stall_enable = ($urandom_range(0, 3) != 0);
      end
      send_random_item();
    end
  endtask

  // Sender holds off until the block has returned everything, then resumes
  task automatic test_drain_pause();
    for (int i = 0; i < 6; i++) send_random_item();
    wait_drained();
    for (int i = 0; i < 6; i++) send_random_item();
  endtask

  // Closing stretch with no idling on either side
  task automatic test_back_to_back(input int count);
    gap_enable   = 1'b0;
    stall_enable = 1'b0;
    for (int i = 0; i < count; i++) send_random_item();
  endtask

  initial begin
    mismatch_count = 0;
    gap_enable     = 1'b1;
    stall_enable   = 1'b1;
    rst            = 1'b1;
    in_ch.valid    = 1'b0;
    in_ch.n_total  = '0;
    in_ch.k_choose = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    test_trivial_cases();
    test_oversize_n();
    test_overflow_edge();
    test_small_values();
    test_random(300);
    test_drain_pause();
    test_back_to_back(40);

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    mismatch_count += pending_coefs.size();
    if (mismatch_count == 0) begin
      $display("binomial_multiplicative_core: match");
    end else begin
      $display("binomial_multiplicative_core: mismatch");
    end
    $finish;
  end

endmodule

[binomial_multiplicative_core.f]
rtl/bmc_pkg.sv
rtl/bmc_in_if.sv
rtl/bmc_out_if.sv
rtl/bmc_front.sv
rtl/bmc_queue.sv
rtl/bmc_back.sv
rtl/binomial_multiplicative_core.sv
tb/binomial_multiplicative_core_tb.sv
